@@ rtl/cau_pkg.sv @@
// Shared types, constants and saturation helpers for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = 2;
  localparam int DIV_QBITS     = 34;
  localparam int DIV_W         = 64 + DIV_QBITS;
  localparam int DIV_CNT_W     = 6;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_DZ  = 3'd4
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } item_t;

  typedef struct packed {
    logic                 done;
    logic                 neg_re;
    logic                 neg_im;
    logic [DIV_QBITS-1:0] q_re;
    logic [DIV_QBITS-1:0] q_im;
  } div_res_t;

  // {overflow, value} from a wide signed value
  function automatic logic [32:0] sat_s65(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > 65'sh0_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -65'sh0_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // {overflow, value} from sign and magnitude
  function automatic logic [32:0] sat_sm(input logic neg, input logic [DIV_QBITS-1:0] q);
    logic [32:0] r;
    if (neg) begin
      if (q > DIV_QBITS'(34'h0_8000_0000)) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, (~q[31:0]) + 32'd1};
      end
    end else begin
      if (q > DIV_QBITS'(34'h0_7FFF_FFFF)) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, q[31:0]};
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/complex_arith_unit.sv @@
// Complex arithmetic unit top level: front end, item queue and back end.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.
//
// An item is taken when start is high and busy is low; its result appears on
// the out_ ports for one cycle with out_valid high and cannot be held off.
// Add, subtract and multiply take one item per cycle while no divide is in
// progress and pass through the queue, product stage, sum stage and output
// register. A divide runs on a one-bit-per-cycle divider and holds the back
// end until it finishes; meanwhile later items wait in the four-entry queue;
// busy rises when the queue is full. Results leave in the order they came in.
module complex_arith_unit import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  output logic               out_valid,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic               out_overflow,
  output logic               out_div_zero
);

  logic  push, pop, q_empty, q_full;
  item_t push_item, pop_item;

  cau_front u_front (
    .start   (start),
    .full    (q_full),
    .in_mode (in_mode),
    .in_a_re (in_a_re),
    .in_a_im (in_a_im),
    .in_b_re (in_b_re),
    .in_b_im (in_b_im),
    .busy    (busy),
    .push    (push),
    .item    (push_item)
  );

  cau_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_res_re   (out_res_re),
    .out_res_im   (out_res_im),
    .out_overflow (out_overflow),
    .out_div_zero (out_div_zero)
  );

endmodule

@@ rtl/cau_front.sv @@
// Front end: accepts items and classifies them into internal operations.
// Depends on cau_pkg.
module cau_front import cau_pkg::*; (
  input  logic               start,
  input  logic               full,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  output logic               busy,
  output logic               push,
  output item_t              item
);

  op_t op;

  always_comb begin
    case (in_mode)
      MODE_ADD: op = OP_ADD;
      MODE_SUB: op = OP_SUB;
      MODE_MUL: op = OP_MUL;
      MODE_DIV: op = (in_b_re == 32'sd0 && in_b_im == 32'sd0) ? OP_DZ : OP_DIV;
      default:  op = OP_ADD;
    endcase
  end

  assign busy      = full;
  assign push      = start && !full;
  assign item.op   = op;
  assign item.a_re = in_a_re;
  assign item.a_im = in_a_im;
  assign item.b_re = in_b_re;
  assign item.b_im = in_b_im;

endmodule

@@ rtl/cau_queue.sv @@
// Short item queue between front and back end.
// Depends on cau_pkg.
module cau_queue import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty,
  output logic  full
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    if (pop && !push) cnt_nxt = cnt_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_W'(1);
      if (pop)  rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

  assign pop_item = mem_r[rp_r];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));

endmodule

@@ rtl/cau_div.sv @@
// Restoring divider: two quotients over a shared divisor, one bit per cycle.
// Depends on cau_pkg.
module cau_div import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        neg_re,
  input  logic        neg_im,
  input  logic [63:0] mag_re,
  input  logic [63:0] mag_im,
  input  logic [63:0] den,
  output logic        busy,
  output div_res_t    res
);

  logic                 busy_r, done_r, neg_re_r, neg_im_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_re_r, rem_im_r, d_r;
  logic [DIV_QBITS-1:0] q_re_r, q_im_r;
  logic                 ge_re, ge_im;

  assign ge_re = rem_re_r >= d_r;
  assign ge_im = rem_im_r >= d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_QBITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_re_r <= DIV_W'(mag_re) << FRAC_BITS;
      rem_im_r <= DIV_W'(mag_im) << FRAC_BITS;
      d_r      <= DIV_W'(den) << (DIV_QBITS - 1);
      q_re_r   <= '0;
      q_im_r   <= '0;
      neg_re_r <= neg_re;
      neg_im_r <= neg_im;
    end else if (busy_r) begin
      if (ge_re) rem_re_r <= rem_re_r - d_r;
      if (ge_im) rem_im_r <= rem_im_r - d_r;
      q_re_r <= {q_re_r[DIV_QBITS-2:0], ge_re};
      q_im_r <= {q_im_r[DIV_QBITS-2:0], ge_im};
      d_r    <= d_r >> 1;
    end
  end

  assign busy       = busy_r;
  assign res.done   = done_r;
  assign res.neg_re = neg_re_r;
  assign res.neg_im = neg_im_r;
  assign res.q_re   = q_re_r;
  assign res.q_im   = q_im_r;

endmodule

@@ rtl/cau_back.sv @@
// Back end: product stage, sum stage, saturation and the shared divider.
// Depends on cau_pkg and cau_div.
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               pop,
  output logic               out_valid,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic               out_overflow,
  output logic               out_div_zero
);

  logic               s1_vld_r;
  op_t                s1_op_r;
  logic signed [31:0] s1_a_re_r, s1_a_im_r, s1_b_re_r, s1_b_im_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_qq_r;

  logic               s2_vld_r;
  op_t                s2_op_r;
  logic signed [64:0] s2_re_r, s2_im_r, s2_re_nxt, s2_im_nxt;
  logic [63:0]        s2_den_r;

  logic               out_vld_r, out_ovf_r, out_dz_r;
  logic [31:0]        out_re_r, out_im_r;

  logic               div_busy, div_active, div_start;
  div_res_t           div_res;
  logic signed [64:0] sh_re, sh_im, abs_re, abs_im;
  logic [32:0]        sat_re, sat_im, dsat_re, dsat_im;

  assign div_active = (s1_vld_r && s1_op_r == OP_DIV) || (s2_vld_r && s2_op_r == OP_DIV)
                      || div_busy;
  assign pop        = !q_empty && !div_active;

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op_r   <= q_item.op;
      s1_a_re_r <= q_item.a_re;
      s1_a_im_r <= q_item.a_im;
      s1_b_re_r <= q_item.b_re;
      s1_b_im_r <= q_item.b_im;
      p_rr_r    <= q_item.a_re * q_item.b_re;
      p_ii_r    <= q_item.a_im * q_item.b_im;
      p_ri_r    <= q_item.a_re * q_item.b_im;
      p_ir_r    <= q_item.a_im * q_item.b_re;
      p_bb_r    <= q_item.b_re * q_item.b_re;
      p_qq_r    <= q_item.b_im * q_item.b_im;
    end
  end

  always_comb begin
    case (s1_op_r)
      OP_ADD: begin
        s2_re_nxt = 65'(s1_a_re_r) + 65'(s1_b_re_r);
        s2_im_nxt = 65'(s1_a_im_r) + 65'(s1_b_im_r);
      end
      OP_SUB: begin
        s2_re_nxt = 65'(s1_a_re_r) - 65'(s1_b_re_r);
        s2_im_nxt = 65'(s1_a_im_r) - 65'(s1_b_im_r);
      end
      OP_MUL: begin
        s2_re_nxt = 65'(p_rr_r) - 65'(p_ii_r);
        s2_im_nxt = 65'(p_ri_r) + 65'(p_ir_r);
      end
      OP_DIV: begin
        s2_re_nxt = 65'(p_rr_r) + 65'(p_ii_r);
        s2_im_nxt = 65'(p_ir_r) - 65'(p_ri_r);
      end
      default: begin
        s2_re_nxt = '0;
        s2_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s2_op_r  <= s1_op_r;
    s2_re_r  <= s2_re_nxt;
    s2_im_r  <= s2_im_nxt;
    s2_den_r <= 64'(p_bb_r) + 64'(p_qq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= pop;
      s2_vld_r <= s1_vld_r;
    end
  end

  assign sh_re   = (s2_op_r == OP_MUL) ? (s2_re_r >>> FRAC_BITS) : s2_re_r;
  assign sh_im   = (s2_op_r == OP_MUL) ? (s2_im_r >>> FRAC_BITS) : s2_im_r;
  assign sat_re  = sat_s65(sh_re);
  assign sat_im  = sat_s65(sh_im);
  assign abs_re  = s2_re_r[64] ? -s2_re_r : s2_re_r;
  assign abs_im  = s2_im_r[64] ? -s2_im_r : s2_im_r;
  assign div_start = s2_vld_r && s2_op_r == OP_DIV;

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .neg_re (s2_re_r[64]),
    .neg_im (s2_im_r[64]),
    .mag_re (abs_re[63:0]),
    .mag_im (abs_im[63:0]),
    .den    (s2_den_r),
    .busy   (div_busy),
    .res    (div_res)
  );

  assign dsat_re = sat_sm(div_res.neg_re && div_res.q_re != '0, div_res.q_re);
  assign dsat_im = sat_sm(div_res.neg_im && div_res.q_im != '0, div_res.q_im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= (s2_vld_r && s2_op_r != OP_DIV) || div_res.done;
    end
  end

  always_ff @(posedge clk) begin
    if (div_res.done) begin
      out_re_r  <= dsat_re[31:0];
      out_im_r  <= dsat_im[31:0];
      out_ovf_r <= dsat_re[32] || dsat_im[32];
      out_dz_r  <= 1'b0;
    end else if (s2_vld_r && s2_op_r == OP_DZ) begin
      out_re_r  <= '0;
      out_im_r  <= '0;
      out_ovf_r <= 1'b0;
      out_dz_r  <= 1'b1;
    end else if (s2_vld_r) begin
      out_re_r  <= sat_re[31:0];
      out_im_r  <= sat_im[31:0];
      out_ovf_r <= sat_re[32] || sat_im[32];
      out_dz_r  <= 1'b0;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_res_re   = out_re_r;
  assign out_res_im   = out_im_r;
  assign out_overflow = out_ovf_r;
  assign out_div_zero = out_dz_r;

endmodule

@@ rtl/cau_checker.sv @@
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on complex_arith_unit.
module cau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_res_re,
  input logic [31:0] out_res_im,
  input logic        out_overflow,
  input logic        out_div_zero
);

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_overflow && out_div_zero))
    else $error("overflow and divide-by-zero both set");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_res_re == 32'd0 && out_res_im == 32'd0)
    else $error("divide-by-zero result not zero");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("activity right after reset");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_res_re   (out_res_re),
  .out_res_im   (out_res_im),
  .out_overflow (out_overflow),
  .out_div_zero (out_div_zero)
);
